[rtl/core/ale_pkg.sv]
// Package with shared types, register indexes, line codes and helper functions.
`default_nettype none

package ale_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_SLOW      = 3'd1;
  localparam logic [2:0] REG_TOP       = 3'd2;
  localparam logic [2:0] REG_RED_POS   = 3'd3;
  localparam logic [2:0] REG_GREEN_POS = 3'd4;
  localparam logic [2:0] REG_BLUE_POS  = 3'd5;
  localparam logic [2:0] REG_WHITE_POS = 3'd6;

  // Serial line codes, two data bits per byte
  localparam logic [7:0] CODE_11 = 8'h77;
  localparam logic [7:0] CODE_10 = 8'h17;
  localparam logic [7:0] CODE_01 = 8'h71;
  localparam logic [7:0] CODE_00 = 8'h11;

  // Duty percentages of the timer period
  localparam logic [6:0] ONE_PCT_FAST  = 7'd64;
  localparam logic [6:0] ZERO_PCT_FAST = 7'd32;
  localparam logic [6:0] ONE_PCT_SLOW  = 7'd50;
  localparam logic [6:0] ZERO_PCT_SLOW = 7'd20;

  // x / 100 as (x * 5243) >> 19, exact for x below 16384
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Byte counts less one for each LED layout
  localparam logic [4:0] LAST_SER_3 = 5'd11;
  localparam logic [4:0] LAST_SER_4 = 5'd15;
  localparam logic [4:0] LAST_TIM_3 = 5'd23;
  localparam logic [4:0] LAST_TIM_4 = 5'd31;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [7:0] brightness;
  } ale_pix_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] red_pos;
    logic [1:0] green_pos;
    logic [1:0] blue_pos;
    logic [1:0] white_pos;
    logic [7:0] one_duty;
    logic [7:0] zero_duty;
  } ale_cfg_t;

  typedef struct packed {
    logic [3:0][7:0] val;
    logic            four;
  } ale_slots_t;

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(RECIP_100);
    return 8'(p >> RECIP_SHIFT);
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] b);
    logic [16:0] p;
    p = 17'(c) * (17'(b) + 17'd1);
    return 8'(p >> 8);
  endfunction

  function automatic logic [7:0] serial_code(input logic [1:0] pair);
    logic [7:0] code;
    case (pair)
      2'b11: code = CODE_11;
      2'b10: code = CODE_10;
      2'b01: code = CODE_01;
      default: code = CODE_00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ale_if.sv]
// Stream interfaces for the LED colour input and the coded byte output.
`default_nettype none

interface ale_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] white;
  logic [7:0] brightness;

  modport source (output valid, red, green, blue, white, brightness, input ready);
  modport sink (input valid, red, green, blue, white, brightness, output ready);
endinterface

interface ale_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;

  modport source (output valid, code_byte, last, input ready);
  modport sink (input valid, code_byte, last, output ready);
endinterface

`default_nettype wire

[rtl/core/ale_cfg.sv]
// Configuration registers and the registered timer duty values.
`default_nettype none

module ale_cfg
  import ale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output ale_cfg_t        cfg
);

  logic       mode;
  logic       slow;
  logic [7:0] top;
  logic [1:0] red_pos;
  logic [1:0] green_pos;
  logic [1:0] blue_pos;
  logic [1:0] white_pos;
  logic [13:0] prod_one;
  logic [13:0] prod_zero;
  logic [7:0] one_duty;
  logic [7:0] zero_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      slow      <= 1'b0;
      top       <= 8'd0;
      red_pos   <= 2'd1;
      green_pos <= 2'd0;
      blue_pos  <= 2'd2;
      white_pos <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[0];
        REG_SLOW:      slow      <= cfg_data[0];
        REG_TOP:       top       <= cfg_data;
        REG_RED_POS:   red_pos   <= cfg_data[1:0];
        REG_GREEN_POS: green_pos <= cfg_data[1:0];
        REG_BLUE_POS:  blue_pos  <= cfg_data[1:0];
        REG_WHITE_POS: white_pos <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Duty values follow a timer_top or slow_rate write via the product registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_one  <= 14'd0;
      prod_zero <= 14'd0;
      one_duty  <= 8'd0;
      zero_duty <= 8'd0;
    end else begin
      prod_one  <= 14'(top) * 14'(slow ? ONE_PCT_SLOW : ONE_PCT_FAST);
      prod_zero <= 14'(top) * 14'(slow ? ZERO_PCT_SLOW : ZERO_PCT_FAST);
      one_duty  <= div100(prod_one);
      zero_duty <= div100(prod_zero);
    end
  end

  always_comb begin
    cfg.mode      = mode;
    cfg.red_pos   = red_pos;
    cfg.green_pos = green_pos;
    cfg.blue_pos  = blue_pos;
    cfg.white_pos = white_pos;
    cfg.one_duty  = one_duty;
    cfg.zero_duty = zero_duty;
  end

endmodule

`default_nettype wire

[rtl/core/ale_pack.sv]
// Brightness scaling and placement of the colours into wire slots.
`default_nettype none

module ale_pack
  import ale_pkg::*;
(
  input  ale_pix_t   pix,
  input  ale_cfg_t   cfg,
  output ale_slots_t slots
);

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] w;
  logic       four;

  assign r    = scale_chan(pix.red, pix.brightness);
  assign g    = scale_chan(pix.green, pix.brightness);
  assign b    = scale_chan(pix.blue, pix.brightness);
  assign w    = scale_chan(pix.white, pix.brightness);
  assign four = (cfg.red_pos != cfg.white_pos);

  // Later colours in the order white, red, green, blue take a shared slot.
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      slots.val[s] = 8'd0;
      if (four && cfg.white_pos == 2'(s)) slots.val[s] = w;
      if (cfg.red_pos == 2'(s))   slots.val[s] = r;
      if (cfg.green_pos == 2'(s)) slots.val[s] = g;
      if (cfg.blue_pos == 2'(s))  slots.val[s] = b;
    end
    slots.four = four;
  end

endmodule

`default_nettype wire

[rtl/core/ale_ser.sv]
// Serialiser that turns the slot values into coded line bytes, one beat a cycle unless the output stalls.
`default_nettype none

module ale_ser
  import ale_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load_valid,
  output logic       load_ready,
  input  ale_slots_t slots,
  input  ale_cfg_t   cfg,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] code_byte,
  output logic       last
);

  logic        busy;
  logic [31:0] sh;
  logic [4:0]  cnt;
  logic        advance;
  logic        finishing;
  logic        load;
  logic [7:0]  byte_next;
  logic [4:0]  cnt_load;

  assign advance    = busy && (!out_valid || out_ready);
  assign finishing  = advance && (cnt == 5'd0);
  assign load_ready = !busy || finishing;
  assign load       = load_valid && load_ready;

  assign byte_next = cfg.mode ? (sh[31] ? cfg.one_duty : cfg.zero_duty)
                              : serial_code(sh[31:30]);

  always_comb begin
    if (cfg.mode) cnt_load = slots.four ? LAST_TIM_4 : LAST_TIM_3;
    else          cnt_load = slots.four ? LAST_SER_4 : LAST_SER_3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_byte <= byte_next;
      last      <= (cnt == 5'd0);
    end
    if (load) begin
      sh  <= {slots.val[0], slots.val[1], slots.val[2], slots.val[3]};
      cnt <= cnt_load;
    end else if (advance) begin
      sh  <= cfg.mode ? {sh[30:0], 1'b0} : {sh[29:0], 2'b00};
      cnt <= cnt - 5'd1;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !advance |=> busy && $stable(cnt) && $stable(sh))
    else $error("serialiser state moved while the output was stalled");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    advance && cnt != 5'd0 |=> busy && cnt == $past(cnt) - 5'd1)
    else $error("byte count did not step down by one");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    finishing && !load_valid |=> !busy)
    else $error("serialiser stayed busy after the final byte");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && (last == ($past(cnt) == 5'd0)))
    else $error("last flag does not match the byte count");
`endif

endmodule

`default_nettype wire

[rtl/core/addressable_led_bit_encoder.sv]
// Top level of the addressable LED bit encoder.
`default_nettype none

// Each beat on led_in is one LED colour with a brightness; the block scales the
// channels, orders them by the slot positions and sends them MSB first on led_out
// as coded line bytes, one beat per cycle unless led_out stalls. An LED yields 12
// bytes (three slots) or 16 bytes (four slots) in serial mode and 24 or 32 bytes
// in timer mode; last marks its final byte. The serialiser, one byte a cycle when
// not stalled, sets the rate; the next LED, held in the input register, loads as
// the final byte is registered, so LEDs follow without a gap. The first byte
// passes the input register and the serialiser's shift register before led_out
// registers it. Configuration is written via cfg_we, cfg_index and cfg_data; the
// user must write it only while the block is idle; the block does not enforce it.
// Duty values follow timer_top or slow_rate writes via product and duty registers.
module addressable_led_bit_encoder
  import ale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  ale_in_if.sink          led_in,
  ale_out_if.source       led_out,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  ale_cfg_t   cfg;
  ale_slots_t slots;
  ale_pix_t   pix;
  logic       pix_valid;
  logic       load_ready;
  logic       in_take;

  assign led_in.ready = !pix_valid || load_ready;
  assign in_take      = led_in.valid && led_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (led_in.ready) begin
      pix_valid <= led_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pix.red        <= led_in.red;
      pix.green      <= led_in.green;
      pix.blue       <= led_in.blue;
      pix.white      <= led_in.white;
      pix.brightness <= led_in.brightness;
    end
  end

  ale_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ale_pack u_pack (
    .pix   (pix),
    .cfg   (cfg),
    .slots (slots)
  );

  ale_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (pix_valid),
    .load_ready (load_ready),
    .slots      (slots),
    .cfg        (cfg),
    .out_valid  (led_out.valid),
    .out_ready  (led_out.ready),
    .code_byte  (led_out.code_byte),
    .last       (led_out.last)
  );

endmodule

`default_nettype wire
